/* hw/rtl/bsl_pkg.sv */
// Package for the bounded sequence list unit: sizes, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package bsl_pkg;

  // Store depth and derived widths
  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 2) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  // Common width for compares between the 5-bit position field and the count
  localparam int WIDE_W     = (CNT_W > 5) ? CNT_W : 5;

  // Fixed field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd1;
  localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] OP_INSERT     = 3'd4;
  localparam logic [MODE_W-1:0] OP_ERASE      = 3'd5;
  localparam logic [MODE_W-1:0] OP_FIND       = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  // Read address selects
  localparam logic [1:0] RD_CUR  = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic              load;        // latch a new request
    logic              rd_en;       // read the store
    logic [1:0]        rd_sel;      // read at idx, idx-1 or idx+1
    logic              wr_en;       // write the store at idx
    logic              wr_key;      // write data: key (1) or read data (0)
    logic              idx_inc;
    logic              idx_dec;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              set_found;
    logic              publish;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_full;
    logic              is_empty;
    logic              pos_gt_cnt;
    logic              pos_ge_cnt;
    logic              idx_gt_tgt;
    logic              more_left;   // idx + 1 < count
    logic              idx_lt_cnt;
    logic              match;       // read data equals key
    logic              out_free;    // output register can take a result
  } stat_t;

endpackage

/* hw/rtl/bounded_sequence_list_unit.sv */
// Top level of the bounded sequence list unit: stream ports, controller and
// datapath. Depends on bsl_pkg, bsl_ctrl and bsl_datapath.

// An ordered list of up to LIST_DEPTH signed 32-bit values. One request is
// taken at a time and gives one result. Pop back only lowers the count; push
// back writes the value at the end. Push front, pop front, insert and erase
// shift the later entries one place, each moved entry by a registered read
// and then a write. Find scans from index 0, reading each entry and then
// comparing it with the key. A failed request (full, empty, bad position,
// unused mode) leaves the list unchanged. A result waits in the output
// register while the next request is already being taken.
module bounded_sequence_list_unit
  import bsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode[2:0], position[7:3], value[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], found_position[5:2], count[10:6], zero
);

  cmd_t               cmd;
  stat_t              st;
  logic [STAT_W-1:0]  out_status;
  logic [FOUND_W-1:0] out_found;
  logic [COUNT_W-1:0] out_count;

  bsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .ready    (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bsl_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (s_tdata[2:0]),
    .in_pos     (s_tdata[7:3]),
    .in_value   (s_tdata[39:8]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_count  (out_count)
  );

  assign m_tdata = {5'd0, out_count, out_found, out_status};

endmodule

/* hw/rtl/bsl_ctrl.sv */
// Controller state machine of the bounded sequence list unit.
// Sequences shift and scan loops; depends on bsl_pkg.
module bsl_ctrl
  import bsl_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVAL  = 4'd1;
  localparam logic [3:0] S_SHR   = 4'd2;
  localparam logic [3:0] S_SHR_W = 4'd3;
  localparam logic [3:0] S_SHL   = 4'd4;
  localparam logic [3:0] S_SHL_W = 4'd5;
  localparam logic [3:0] S_FR    = 4'd6;
  localparam logic [3:0] S_FC    = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_FIN;
        case (st.mode)
          OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (st.is_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              state_next = S_SHR;
            end
          end
          OP_INSERT: begin
            if (st.is_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (st.pos_gt_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD;
            end else begin
              state_next = S_SHR;
            end
          end
          OP_POP_BACK: begin
            if (st.is_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (st.is_empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD;
            end else begin
              state_next = S_SHL;
            end
          end
          OP_ERASE: begin
            if (st.pos_ge_cnt) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BAD;
            end else begin
              state_next = S_SHL;
            end
          end
          OP_FIND: begin
            state_next = S_FR;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BAD;
          end
        endcase
      end
      // Open a gap: move entries up one place from the back down to the target
      S_SHR: begin
        if (st.idx_gt_tgt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_SHR_W;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_SHR_W: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next  = S_SHR;
      end
      // Close the gap: move entries down one place from the target to the back
      S_SHL: begin
        if (st.more_left) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_SHL_W;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_SHL_W: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_SHL;
      end
      // Linear scan for the key
      S_FR: begin
        if (st.idx_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CUR;
          state_next = S_FC;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISSING;
          state_next     = S_FIN;
        end
      end
      S_FC: begin
        if (st.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FR;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/bsl_datapath.sv */
// Datapath of the bounded sequence list unit: list store, index and count
// registers, request latch and output register. Depends on bsl_pkg.
module bsl_datapath
  import bsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [POS_W-1:0]   in_pos,
  input  logic [VAL_W-1:0]   in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic [FOUND_W-1:0] out_found,
  output logic [COUNT_W-1:0] out_count
);

  logic [VAL_W-1:0]   mem [LIST_DEPTH];
  logic [VAL_W-1:0]   rd_data;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   tgt;
  logic [MODE_W-1:0]  mode;
  logic [POS_W-1:0]   pos;
  logic [VAL_W-1:0]   key;
  logic [STAT_W-1:0]  res_status;
  logic [FOUND_W-1:0] res_found;
  logic [CNT_W-1:0]   idx_init;
  logic [CNT_W-1:0]   tgt_init;
  logic [CNT_W-1:0]   rd_ptr;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [WIDE_W-1:0]  pos_wide;
  logic [WIDE_W-1:0]  cnt_wide;
  logic [WIDE_W-1:0]  idx_wide;
  logic [CNT_W:0]     idx_plus;

  assign pos_wide = WIDE_W'(pos);
  assign cnt_wide = WIDE_W'(cnt);
  assign idx_wide = WIDE_W'(idx);
  assign idx_plus = {1'b0, idx} + (CNT_W + 1)'(1);

  // Start index and target of the shift loops, from the incoming request
  always_comb begin
    case (in_mode)
      OP_PUSH_BACK: begin
        idx_init = cnt;
        tgt_init = cnt;
      end
      OP_PUSH_FRONT: begin
        idx_init = cnt;
        tgt_init = '0;
      end
      OP_INSERT: begin
        idx_init = cnt;
        tgt_init = CNT_W'(WIDE_W'(in_pos));
      end
      OP_ERASE: begin
        idx_init = CNT_W'(WIDE_W'(in_pos));
        tgt_init = '0;
      end
      default: begin
        idx_init = '0;
        tgt_init = '0;
      end
    endcase
  end

  // Request latch and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_mode;
      pos  <= in_pos;
      key  <= in_value;
      tgt  <= tgt_init;
    end
    if (cmd.load) begin
      res_status <= ST_OK;
      res_found  <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
      if (cmd.set_found) begin
        res_found <= idx_wide[FOUND_W-1:0];
      end
    end
  end

  // Index register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= idx_init;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - CNT_W'(1);
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Store port addresses
  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_ptr = idx - CNT_W'(1);
      RD_NEXT: rd_ptr = idx_plus[CNT_W-1:0];
      default: rd_ptr = idx;
    endcase
  end
  assign rd_addr = rd_ptr[IDX_W-1:0];
  assign wr_addr = idx[IDX_W-1:0];

  // List store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_key ? key : rd_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_count  <= cnt_wide[COUNT_W-1:0];
    end
  end

  // Status to the controller
  assign st.mode       = mode;
  assign st.is_full    = (cnt == CNT_W'(LIST_DEPTH));
  assign st.is_empty   = (cnt == '0);
  assign st.pos_gt_cnt = (pos_wide > cnt_wide);
  assign st.pos_ge_cnt = (pos_wide >= cnt_wide);
  assign st.idx_gt_tgt = (idx > tgt);
  assign st.more_left  = (idx_plus < {1'b0, cnt});
  assign st.idx_lt_cnt = (idx < cnt);
  assign st.match      = (rd_data == key);
  assign st.out_free   = !out_valid || out_ready;

endmodule
